@@ src/car_pkg.sv @@
// ----------------------------------------------------------------------------
// car_pkg: shared constants and types of the copy alias resolver
// Table geometry, field widths, operation codes and the request and response
// bundles between the sequencer and the chain walker.
// ----------------------------------------------------------------------------
package car_pkg;

  // Table geometry.
  localparam int unsigned MAX_VALUES  = 4096;
  localparam int unsigned CHAIN_LIMIT = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_VALUES);
  localparam int unsigned HOP_W       = $clog2(CHAIN_LIMIT + 1);

  // Item fields.
  localparam int unsigned FIELD_W    = 13;
  localparam int unsigned NUM_OPND   = 6;
  localparam int unsigned KSEL_W     = $clog2(NUM_OPND + 1);
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned IN_USER_W  = OP_W + 1;
  localparam int unsigned OUT_DATA_W = 80;

  // Value count after reset.
  localparam logic [FIELD_W-1:0] VALUE_COUNT_RST = 13'd4096;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_RESOLVE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEFINE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // Start of a chain walk.
  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] idx;
  } walk_req_t;

  // End of a chain walk.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] root;
  } walk_rsp_t;

endpackage

@@ src/car_ram.sv @@
// ----------------------------------------------------------------------------
// car_ram: generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
module car_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read of the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/car_walker.sv @@
// ----------------------------------------------------------------------------
// car_walker: alias chain walker
// Follows the alias table from a start index, one table read per cycle, until
// an entry names itself or the hop limit is reached.
// ----------------------------------------------------------------------------
module car_walker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  car_pkg::walk_req_t        req_i,
  input  logic [car_pkg::IDX_W-1:0] rdata_i,
  output logic [car_pkg::IDX_W-1:0] addr_o,
  output car_pkg::walk_rsp_t        rsp_o
);
  import car_pkg::*;

  logic             busy_q;
  logic [IDX_W-1:0] cur_q;
  logic [HOP_W-1:0] hops_q;
  logic [HOP_W-1:0] hop_next;
  logic             hit;
  logic             last;

  // Read data belongs to cur_q while busy; the next address is that data.
  always_comb begin
    hop_next   = hops_q + 1'b1;
    hit        = (rdata_i == cur_q);
    last       = (hop_next == HOP_W'(CHAIN_LIMIT));
    rsp_o.done = busy_q && (hit || last);
    rsp_o.root = rdata_i;
    addr_o     = busy_q ? rdata_i : req_i.idx;
  end

  // Walk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cur_q  <= '0;
      hops_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cur_q  <= req_i.idx;
      hops_q <= '0;
    end else if (busy_q) begin
      if (rsp_o.done) begin
        busy_q <= 1'b0;
      end else begin
        cur_q  <= rdata_i;
        hops_q <= hop_next;
      end
    end
  end

  // A walk is never restarted while one is running.
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("walk started while busy");

  // The hop count stays below the limit during a walk.
  a_hop_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (hops_q < HOP_W'(CHAIN_LIMIT))) else $error("hop limit exceeded");

  // A finished walk releases the walker.
  a_done_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !busy_q) else $error("walker still busy after done");

endmodule

@@ src/copy_alias_resolver.sv @@
// ----------------------------------------------------------------------------
// copy_alias_resolver: copy propagation alias table
// Resolves operands to their alias roots, records copy definitions and
// clears the table back to identity, one item at a time.
// ----------------------------------------------------------------------------
// Resolve walks the chain of each present operand, r table reads (1..64),
//   and echoes an absent one; define walks only when it follows a copy source.
// A define that writes nothing, a flagged resolve and the unused code do no
//   chain walk and no table write. Clear sweeps all 4096 entries to identity.
// Items do not overlap: a new item is taken only once the last one's result is in the output register.
// After reset the table is swept to identity, input held off.
// ----------------------------------------------------------------------------
module copy_alias_resolver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: value_count.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [car_pkg::FIELD_W-1:0]        cfg_data_i,
  // Input items.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // operand_a, operand_b, operand_c, operand_d, operand_e, operand_f,
  // dest_value, zero fill
  input  logic [car_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // operation, is_copy
  input  logic [car_pkg::IN_USER_W-1:0]      s_axis_tuser,
  // Result items.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // resolved_a, resolved_b, resolved_c, resolved_d, resolved_e, resolved_f,
  // zero fill
  output logic [car_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // range_error
  output logic                               m_axis_tuser
);
  import car_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Control state.
  logic [2:0]         state_q;
  logic [IDX_W-1:0]   sweep_q;
  logic               pend_q;
  logic [KSEL_W-1:0]  k_q;
  logic               m_valid_q;
  logic [FIELD_W-1:0] value_count_q;

  // Item payload.
  logic [OP_W-1:0]    op_q;
  logic [FIELD_W-1:0] opnd_q [NUM_OPND];
  logic [FIELD_W-1:0] dst_q;
  logic               copy_q;
  logic               err_q;
  logic [FIELD_W-1:0] res_q [NUM_OPND];
  logic [IDX_W-1:0]   wval_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic               m_user_q;

  // Combinational.
  logic               s_accept;
  logic               out_free;
  logic [FIELD_W-1:0] cnt;
  logic [FIELD_W-1:0] in_opnd [NUM_OPND];
  logic [FIELD_W-1:0] in_dst;
  logic [OP_W-1:0]    in_op;
  logic               in_copy;
  logic               in_err;
  logic [KSEL_W-1:0]  k_sel;
  logic [FIELD_W-1:0] cur_opnd;
  logic               opnd_done;
  logic               use_src;
  logic [OUT_DATA_W-1:0] out_pack;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [IDX_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_rdata;
  logic [IDX_W-1:0]   walk_addr;
  walk_req_t          walk_req;
  walk_rsp_t          walk_rsp;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Unpack the input transfer and check its indexes against the value count.
  always_comb begin
    cnt = (value_count_q > FIELD_W'(MAX_VALUES)) ? FIELD_W'(MAX_VALUES) : value_count_q;
    for (int i = 0; i < NUM_OPND; i++) begin
      in_opnd[i] = s_axis_tdata[i*FIELD_W +: FIELD_W];
    end
    in_dst  = s_axis_tdata[NUM_OPND*FIELD_W +: FIELD_W];
    in_op   = s_axis_tuser[OP_W-1:0];
    in_copy = s_axis_tuser[OP_W];
    in_err  = 1'b0;
    case (in_op)
      OP_RESOLVE: begin
        for (int i = 0; i < NUM_OPND; i++) begin
          if (!in_opnd[i][FIELD_W-1] && (in_opnd[i] >= cnt)) begin
            in_err = 1'b1;
          end
        end
      end
      OP_DEFINE: begin
        in_err = !in_dst[FIELD_W-1] &&
                 ((in_dst >= cnt) ||
                  (in_copy && !in_opnd[0][FIELD_W-1] && (in_opnd[0] >= cnt)));
      end
      default: in_err = 1'b0;
    endcase
  end

  // Operand under work and the decision to start a chain walk.
  always_comb begin
    k_sel     = (k_q < KSEL_W'(NUM_OPND)) ? k_q : '0;
    cur_opnd  = opnd_q[k_sel];
    opnd_done = (k_q == KSEL_W'(NUM_OPND));
    use_src   = copy_q && !opnd_q[0][FIELD_W-1];
    walk_req.idx   = cur_opnd[IDX_W-1:0];
    walk_req.start = 1'b0;
    if (state_q == ST_RUN && !err_q) begin
      case (op_q)
        OP_RESOLVE: walk_req.start = !opnd_done && !cur_opnd[FIELD_W-1];
        OP_DEFINE:  walk_req.start = !dst_q[FIELD_W-1] && use_src;
        default:    walk_req.start = 1'b0;
      endcase
    end
  end

  // Table port: clearing sweep, define write, or chain walk reads.
  always_comb begin
    ram_we    = (state_q == ST_SWEEP) || (state_q == ST_WRITE);
    ram_wdata = (state_q == ST_SWEEP) ? sweep_q : wval_q;
    if (state_q == ST_SWEEP) begin
      ram_addr = sweep_q;
    end else if (state_q == ST_WRITE) begin
      ram_addr = dst_q[IDX_W-1:0];
    end else begin
      ram_addr = walk_addr;
    end
  end

  // Result packing, resolved_a in the lowest bits.
  always_comb begin
    out_pack = '0;
    for (int i = 0; i < NUM_OPND; i++) begin
      out_pack[i*FIELD_W +: FIELD_W] = res_q[i];
    end
  end

  car_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_VALUES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  car_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (walk_req),
    .rdata_i (ram_rdata),
    .addr_o  (walk_addr),
    .rsp_o   (walk_rsp)
  );

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      sweep_q       <= '0;
      pend_q        <= 1'b0;
      k_q           <= '0;
      m_valid_q     <= 1'b0;
      value_count_q <= VALUE_COUNT_RST;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        value_count_q <= cfg_data_i;
      end
      // A finished item reloads the output register itself below.
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            pend_q  <= 1'b1;
            k_q     <= '0;
            sweep_q <= '0;
            state_q <= (in_op == OP_CLEAR) ? ST_SWEEP : ST_RUN;
          end
        end
        ST_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == IDX_W'(MAX_VALUES - 1)) begin
            state_q <= pend_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_RUN: begin
          if (walk_req.start) begin
            state_q <= ST_WALK;
          end else if (op_q == OP_RESOLVE && !err_q && !opnd_done) begin
            k_q <= k_q + 1'b1;
          end else if (op_q == OP_DEFINE && !err_q && !dst_q[FIELD_W-1]) begin
            state_q <= ST_WRITE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_WALK: begin
          if (walk_rsp.done) begin
            if (op_q == OP_DEFINE) begin
              state_q <= ST_WRITE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_RUN;
            end
          end
        end
        ST_WRITE: state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            pend_q    <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Item payload and results.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          op_q   <= in_op;
          dst_q  <= in_dst;
          copy_q <= in_copy;
          err_q  <= in_err;
          for (int i = 0; i < NUM_OPND; i++) begin
            opnd_q[i] <= in_opnd[i];
            res_q[i]  <= '1;
          end
        end
      end
      ST_RUN: begin
        if (op_q == OP_RESOLVE) begin
          if (err_q) begin
            for (int i = 0; i < NUM_OPND; i++) begin
              res_q[i] <= opnd_q[i];
            end
          end else if (!opnd_done && cur_opnd[FIELD_W-1]) begin
            // An absent operand is echoed unchanged.
            res_q[k_sel] <= cur_opnd;
          end
        end else if (op_q == OP_DEFINE) begin
          res_q[0] <= dst_q;
          wval_q   <= dst_q[IDX_W-1:0];
        end
      end
      ST_WALK: begin
        if (walk_rsp.done) begin
          if (op_q == OP_DEFINE) begin
            wval_q <= walk_rsp.root;
          end else begin
            res_q[k_sel] <= FIELD_W'(walk_rsp.root);
          end
        end
      end
      ST_WRITE: res_q[0] <= FIELD_W'(wval_q);
      ST_DONE: begin
        if (out_free) begin
          m_data_q <= out_pack;
          m_user_q <= err_q;
        end
      end
      default: ;
    endcase
  end

  // The walker reports a result only while the sequencer waits for it.
  a_walk_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_rsp.done |-> (state_q == ST_WALK)) else $error("walk result outside wait");

  // One item at a time: no input transfer right after an accepted one.
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready) else $error("second item taken while busy");

  // A finished item lands in the output register.
  a_result_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> m_axis_tvalid) else $error("result lost");

endmodule
